// ----- design/lfs_pkg.sv -----
`timescale 1ns / 1ps

package lfs_pkg;

   localparam int DEF_MAX_ORDER = 8;
   localparam int DEF_FRAC_BITS = 16;

   localparam int WORD_W     = 32;
   localparam int ROW_W      = 3;
   localparam int COL_W      = 4;
   localparam int ORDER_W    = 4;
   localparam int THRESH_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_ORDER    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_THRESHOLD = 1'd1;

   localparam logic [ORDER_W-1:0]  ORDER_RESET  = 4'd8;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SINGULAR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0]         row_index;
      logic [COL_W-1:0]         col_index;
      logic signed [WORD_W-1:0] element_value;
      logic                     last_element;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0]         solution_index;
      logic signed [WORD_W-1:0] solution_value;
      logic [STATUS_W-1:0]      status;
      logic                     last_result;
   } rsp_payload_type;

endpackage

// ----- design/lfs_req_if.sv -----
`timescale 1ns / 1ps

interface lfs_req_if import lfs_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/lfs_rsp_if.sv -----
`timescale 1ns / 1ps

interface lfs_rsp_if import lfs_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/lu_factor_solve_unit.sv -----
`timescale 1ns / 1ps
// channel    dir   handshake          carries
// req_chan   in    valid / ready      row_index, col_index, element_value, last_element
// rsp_chan   out   valid / ready      solution_index, solution_value, status, last_result
// csr_*      in    csr_write_enable   csr_index, csr_write_data (no read-back)
//
// load items are written to the element store while idle; the item with last_element runs the whole solve
// solve: multiply-subtract steps plus n(n+1)/2 quotients, each one worked
//   in steps (read, start, bit-serial steps, write)
// results leave at one per cycle from the output register when rsp_chan.ready is high
// reset is synchronous, active high; the element store is not cleared
// no item is taken from the last_element item until the final result is registered

module lu_factor_solve_unit import lfs_pkg::*; #(
   parameter int MAX_ORDER = DEF_MAX_ORDER,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   lfs_req_if.sink               req_chan,
   lfs_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int STRIDE = MAX_ORDER + 1;
   localparam int DEPTH  = MAX_ORDER * STRIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int IW     = $clog2(MAX_ORDER);
   localparam int CW     = $clog2(MAX_ORDER + 1);
   localparam int PW     = 2 * WORD_W;
   localparam int NUMW   = WORD_W + FRAC_BITS + 1;
   localparam int DCW    = $clog2(NUMW + 1);
   localparam int REMW   = WORD_W + 1;

   localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_PIV_RD, ST_PIV_CHK,
      ST_L_RD, ST_L_DIV, ST_L_WAIT,
      ST_U_RD_K, ST_U_MUL, ST_U_RND, ST_U_SUB,
      ST_F_RD_B, ST_F_INIT, ST_F_RD_L, ST_F_RD_Y, ST_F_MUL, ST_F_RND, ST_F_SUB, ST_F_WR,
      ST_B_RD_Y, ST_B_INIT, ST_B_RD_U, ST_B_MUL, ST_B_RND, ST_B_SUB,
      ST_B_RD_D, ST_B_DIV, ST_B_WAIT,
      ST_EMIT, ST_SING
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      cell_addr = AW'(int'(r) * STRIDE + int'(c));
   endfunction

   // configuration registers
   logic [ORDER_W-1:0]  order_ff;
   logic [THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= ORDER_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MATRIX_ORDER:    order_ff  <= csr_write_data[ORDER_W-1:0];
            CSR_PIVOT_THRESHOLD: thresh_ff <= csr_write_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // order in use, clamped to 1..MAX_ORDER
   logic [CW-1:0] n_c;
   always_comb begin
      if (order_ff == '0) begin
         n_c = CW'(1);
      end else if (int'(order_ff) > MAX_ORDER) begin
         n_c = CW'(MAX_ORDER);
      end else begin
         n_c = CW'(order_ff);
      end
   end

   // sequencer registers
   state_type                state_ff, state_in;
   logic [CW-1:0]            k_ff, k_in, i_ff, i_in, j_ff, j_in, o_ff, o_in;
   logic                     sat_ff, sat_in;
   logic signed [WORD_W-1:0] p_ff, p_in, l_ff, l_in, acc_ff, acc_in, mq_ff, mq_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_pl_ff, rsp_pl_in;

   // element store, one write and one registered read port
   logic [WORD_W-1:0]        store_mem [DEPTH];
   logic signed [WORD_W-1:0] rdata_ff;
   logic                     we_c;
   logic [AW-1:0]            waddr_c, raddr_c;
   logic [WORD_W-1:0]        wdata_c;

   always_ff @(posedge clock) begin
      if (we_c) begin
         store_mem[waddr_c] <= wdata_c;
      end
      rdata_ff <= store_mem[raddr_c];
   end

   // solution vector, one read address chosen by phase
   logic signed [WORD_W-1:0] x_ff [MAX_ORDER];
   logic                     x_we_c;
   logic [IW-1:0]            x_ridx_c;
   logic signed [WORD_W-1:0] x_rd_c;

   assign x_ridx_c = (state_ff == ST_EMIT) ? o_ff[IW-1:0] : j_ff[IW-1:0];
   assign x_rd_c   = x_ff[x_ridx_c];

   // shared multiplier, registered product
   logic signed [WORD_W-1:0] mul_a_c, mul_b_c;
   logic signed [PW-1:0]     prod_ff;

   assign mul_a_c = (state_ff == ST_B_MUL) ? rdata_ff : l_ff;
   assign mul_b_c = (state_ff == ST_B_MUL) ? x_rd_c : rdata_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a_c * mul_b_c;
   end

   // product rounding half up and saturation
   logic signed [PW-1:0]     rnd_t_c, rnd_q_c;
   logic signed [WORD_W-1:0] rnd_val_c;
   logic                     rnd_sat_c;

   always_comb begin
      rnd_t_c   = prod_ff + RND_HALF;
      rnd_q_c   = rnd_t_c >>> FRAC_BITS;
      rnd_sat_c = (rnd_q_c[PW-1:WORD_W-1] != '0) && (rnd_q_c[PW-1:WORD_W-1] != '1);
      if (rnd_sat_c) begin
         rnd_val_c = rnd_q_c[PW-1] ? WMIN : WMAX;
      end else begin
         rnd_val_c = rnd_q_c[WORD_W-1:0];
      end
   end

   // saturating subtract acc - mq
   logic [WORD_W:0]          sub_t_c;
   logic signed [WORD_W-1:0] sub_val_c;
   logic                     sub_sat_c;

   always_comb begin
      sub_t_c   = {acc_ff[WORD_W-1], acc_ff} - {mq_ff[WORD_W-1], mq_ff};
      sub_sat_c = sub_t_c[WORD_W] != sub_t_c[WORD_W-1];
      if (sub_sat_c) begin
         sub_val_c = sub_t_c[WORD_W] ? WMIN : WMAX;
      end else begin
         sub_val_c = sub_t_c[WORD_W-1:0];
      end
   end

   // bit-serial restoring divider, quotient rounded half away from zero
   logic                     dv_start_c;
   logic signed [WORD_W-1:0] dv_a_c, dv_d_c;
   logic [WORD_W-1:0]        dv_ua_c, dv_ud_c;
   logic [NUMW-1:0]          dv_num_c;
   logic                     dv_busy_ff;
   logic [DCW-1:0]           dv_cnt_ff;
   logic [NUMW-1:0]          dv_num_ff, dv_quo_ff;
   logic [REMW-1:0]          dv_rem_ff, dv_rem_step_c;
   logic [REMW:0]            dv_rem_sh_c;
   logic                     dv_qbit_c;
   logic [WORD_W-1:0]        dv_den_ff;
   logic                     dv_neg_ff, dv_zero_ff;
   logic signed [WORD_W-1:0] dv_q_c;
   logic                     dv_sat_c;

   assign dv_start_c = (state_ff == ST_L_DIV) || (state_ff == ST_B_DIV);
   assign dv_a_c     = (state_ff == ST_L_DIV) ? rdata_ff : acc_ff;
   assign dv_d_c     = (state_ff == ST_L_DIV) ? p_ff : rdata_ff;
   assign dv_ua_c    = dv_a_c[WORD_W-1] ? WORD_W'(-dv_a_c) : WORD_W'(dv_a_c);
   assign dv_ud_c    = dv_d_c[WORD_W-1] ? WORD_W'(-dv_d_c) : WORD_W'(dv_d_c);
   assign dv_num_c   = {1'b0, dv_ua_c, {FRAC_BITS{1'b0}}} + NUMW'(dv_ud_c >> 1);

   always_comb begin
      dv_rem_sh_c = {dv_rem_ff, dv_num_ff[NUMW-1]};
      if (dv_rem_sh_c >= (REMW+1)'(dv_den_ff)) begin
         dv_qbit_c     = 1'b1;
         dv_rem_step_c = REMW'(dv_rem_sh_c - (REMW+1)'(dv_den_ff));
      end else begin
         dv_qbit_c     = 1'b0;
         dv_rem_step_c = REMW'(dv_rem_sh_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
         dv_cnt_ff  <= '0;
      end else if (dv_start_c) begin
         dv_busy_ff <= 1'b1;
         dv_cnt_ff  <= DCW'(NUMW);
      end else if (dv_busy_ff) begin
         dv_cnt_ff <= dv_cnt_ff - DCW'(1);
         if (dv_cnt_ff == DCW'(1)) begin
            dv_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dv_start_c) begin
         dv_num_ff  <= dv_num_c;
         dv_rem_ff  <= '0;
         dv_quo_ff  <= '0;
         dv_den_ff  <= dv_ud_c;
         dv_neg_ff  <= dv_a_c[WORD_W-1] ^ dv_d_c[WORD_W-1];
         dv_zero_ff <= (dv_ud_c == '0);
      end else if (dv_busy_ff) begin
         dv_num_ff <= {dv_num_ff[NUMW-2:0], 1'b0};
         dv_rem_ff <= dv_rem_step_c;
         dv_quo_ff <= {dv_quo_ff[NUMW-2:0], dv_qbit_c};
      end
   end

   always_comb begin
      dv_sat_c = 1'b0;
      if (dv_zero_ff) begin
         dv_q_c = '0;
      end else if (dv_neg_ff) begin
         if (dv_quo_ff > NUMW'(WMIN)) begin
            dv_q_c   = WMIN;
            dv_sat_c = 1'b1;
         end else begin
            dv_q_c = -dv_quo_ff[WORD_W-1:0];
         end
      end else begin
         if (dv_quo_ff > NUMW'(WMAX)) begin
            dv_q_c   = WMAX;
            dv_sat_c = 1'b1;
         end else begin
            dv_q_c = dv_quo_ff[WORD_W-1:0];
         end
      end
   end

   // pivot test against the threshold
   logic [WORD_W-1:0] p_mag_c;
   logic              singular_c;

   assign p_mag_c    = rdata_ff[WORD_W-1] ? WORD_W'(-rdata_ff) : WORD_W'(rdata_ff);
   assign singular_c = (rdata_ff == '0) || (p_mag_c < WORD_W'(thresh_ff));

   // load path
   logic load_ok_c;
   logic [AW-1:0] load_addr_c;

   assign load_ok_c   = (int'(req_chan.payload.row_index) < int'(n_c)) &&
                        (int'(req_chan.payload.col_index) <= int'(n_c));
   assign load_addr_c = cell_addr(CW'(req_chan.payload.row_index),
                                  CW'(req_chan.payload.col_index));

   logic slot_free_c;
   assign slot_free_c = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_pl_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      o_in         = o_ff;
      sat_in       = sat_ff;
      p_in         = p_ff;
      l_in         = l_ff;
      acc_in       = acc_ff;
      mq_in        = mq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pl_in    = rsp_pl_ff;
      we_c         = 1'b0;
      waddr_c      = '0;
      wdata_c      = '0;
      raddr_c      = '0;
      x_we_c       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (load_ok_c) begin
                  we_c    = 1'b1;
                  waddr_c = load_addr_c;
                  wdata_c = req_chan.payload.element_value;
               end
               if (req_chan.payload.last_element) begin
                  k_in     = '0;
                  sat_in   = 1'b0;
                  state_in = ST_PIV_RD;
               end
            end
         end
         // factorization: pivot k
         ST_PIV_RD: begin
            raddr_c  = cell_addr(k_ff, k_ff);
            state_in = ST_PIV_CHK;
         end
         ST_PIV_CHK: begin
            p_in = rdata_ff;
            if (singular_c) begin
               state_in = ST_SING;
            end else if (k_ff + CW'(1) < n_c) begin
               i_in     = k_ff + CW'(1);
               state_in = ST_L_RD;
            end else begin
               i_in     = '0;
               state_in = ST_F_RD_B;
            end
         end
         // multiplier l = a(i,k) / pivot
         ST_L_RD: begin
            raddr_c  = cell_addr(i_ff, k_ff);
            state_in = ST_L_DIV;
         end
         ST_L_DIV: begin
            state_in = ST_L_WAIT;
         end
         ST_L_WAIT: begin
            if (!dv_busy_ff) begin
               l_in     = dv_q_c;
               sat_in   = sat_ff | dv_sat_c;
               we_c     = 1'b1;
               waddr_c  = cell_addr(i_ff, k_ff);
               wdata_c  = dv_q_c;
               j_in     = k_ff + CW'(1);
               state_in = ST_U_RD_K;
            end
         end
         // row update a(i,j) -= l * a(k,j)
         ST_U_RD_K: begin
            raddr_c  = cell_addr(k_ff, j_ff);
            state_in = ST_U_MUL;
         end
         ST_U_MUL: begin
            raddr_c  = cell_addr(i_ff, j_ff);
            state_in = ST_U_RND;
         end
         ST_U_RND: begin
            acc_in   = rdata_ff;
            mq_in    = rnd_val_c;
            sat_in   = sat_ff | rnd_sat_c;
            state_in = ST_U_SUB;
         end
         ST_U_SUB: begin
            we_c    = 1'b1;
            waddr_c = cell_addr(i_ff, j_ff);
            wdata_c = sub_val_c;
            sat_in  = sat_ff | sub_sat_c;
            if (j_ff + CW'(1) < n_c) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_U_RD_K;
            end else if (i_ff + CW'(1) < n_c) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_L_RD;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = ST_PIV_RD;
            end
         end
         // forward substitution into the right-hand column
         ST_F_RD_B: begin
            raddr_c  = cell_addr(i_ff, n_c);
            state_in = ST_F_INIT;
         end
         ST_F_INIT: begin
            acc_in = rdata_ff;
            j_in   = '0;
            if (i_ff == '0) begin
               state_in = ST_F_WR;
            end else begin
               state_in = ST_F_RD_L;
            end
         end
         ST_F_RD_L: begin
            raddr_c  = cell_addr(i_ff, j_ff);
            state_in = ST_F_RD_Y;
         end
         ST_F_RD_Y: begin
            l_in     = rdata_ff;
            raddr_c  = cell_addr(j_ff, n_c);
            state_in = ST_F_MUL;
         end
         ST_F_MUL: begin
            state_in = ST_F_RND;
         end
         ST_F_RND: begin
            mq_in    = rnd_val_c;
            sat_in   = sat_ff | rnd_sat_c;
            state_in = ST_F_SUB;
         end
         ST_F_SUB: begin
            acc_in = sub_val_c;
            sat_in = sat_ff | sub_sat_c;
            if (j_ff + CW'(1) < i_ff) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_F_RD_L;
            end else begin
               state_in = ST_F_WR;
            end
         end
         ST_F_WR: begin
            we_c    = 1'b1;
            waddr_c = cell_addr(i_ff, n_c);
            wdata_c = acc_ff;
            if (i_ff + CW'(1) < n_c) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_F_RD_B;
            end else begin
               i_in     = n_c - CW'(1);
               state_in = ST_B_RD_Y;
            end
         end
         // back substitution, x(i) from the bottom row up
         ST_B_RD_Y: begin
            raddr_c  = cell_addr(i_ff, n_c);
            state_in = ST_B_INIT;
         end
         ST_B_INIT: begin
            acc_in = rdata_ff;
            j_in   = i_ff + CW'(1);
            if (i_ff + CW'(1) < n_c) begin
               state_in = ST_B_RD_U;
            end else begin
               state_in = ST_B_RD_D;
            end
         end
         ST_B_RD_U: begin
            raddr_c  = cell_addr(i_ff, j_ff);
            state_in = ST_B_MUL;
         end
         ST_B_MUL: begin
            state_in = ST_B_RND;
         end
         ST_B_RND: begin
            mq_in    = rnd_val_c;
            sat_in   = sat_ff | rnd_sat_c;
            state_in = ST_B_SUB;
         end
         ST_B_SUB: begin
            acc_in = sub_val_c;
            sat_in = sat_ff | sub_sat_c;
            if (j_ff + CW'(1) < n_c) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_B_RD_U;
            end else begin
               state_in = ST_B_RD_D;
            end
         end
         ST_B_RD_D: begin
            raddr_c  = cell_addr(i_ff, i_ff);
            state_in = ST_B_DIV;
         end
         ST_B_DIV: begin
            state_in = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            if (!dv_busy_ff) begin
               x_we_c = 1'b1;
               sat_in = sat_ff | dv_sat_c;
               if (i_ff == '0) begin
                  o_in     = '0;
                  state_in = ST_EMIT;
               end else begin
                  i_in     = i_ff - CW'(1);
                  state_in = ST_B_RD_Y;
               end
            end
         end
         // deliver x(0..n-1) through the output register
         ST_EMIT: begin
            if (slot_free_c) begin
               rsp_valid_in             = 1'b1;
               rsp_pl_in.solution_index = ROW_W'(o_ff);
               rsp_pl_in.solution_value = x_rd_c;
               rsp_pl_in.status         = sat_ff ? STATUS_SATURATED : STATUS_OK;
               rsp_pl_in.last_result    = (o_ff + CW'(1) == n_c);
               if (o_ff + CW'(1) == n_c) begin
                  state_in = ST_IDLE;
               end else begin
                  o_in = o_ff + CW'(1);
               end
            end
         end
         ST_SING: begin
            if (slot_free_c) begin
               rsp_valid_in             = 1'b1;
               rsp_pl_in.solution_index = ROW_W'(k_ff);
               rsp_pl_in.solution_value = '0;
               rsp_pl_in.status         = STATUS_SINGULAR;
               rsp_pl_in.last_result    = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         o_ff         <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         o_ff         <= o_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff      <= p_in;
      l_ff      <= l_in;
      acc_ff    <= acc_in;
      mq_ff     <= mq_in;
      rsp_pl_ff <= rsp_pl_in;
   end

   always_ff @(posedge clock) begin
      if (x_we_c) begin
         x_ff[i_ff[IW-1:0]] <= dv_q_c;
      end
   end

`ifndef SYNTHESIS
   // singular result stands alone and carries zero
   a_sing_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.status == STATUS_SINGULAR) |->
      rsp_chan.payload.last_result && (rsp_chan.payload.solution_value == '0))
      else $error("singular result not alone or not zero");

   // divider is never restarted mid-quotient
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      dv_start_c |-> !dv_busy_ff)
      else $error("divider started while busy");

   // divider is quiet whenever new items may arrive
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !dv_busy_ff)
      else $error("divider busy in idle");

   // a new result only comes from the result states
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT) || ($past(state_ff) == ST_SING))
      else $error("result raised outside result states");
`endif

endmodule
